// ===== hw/rtl/sfh_pkg.sv =====
package sfh_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W         = 32;
	localparam int DIFF_W    = W + 1;              // B - A
	localparam int SQ_W      = 2 * DIFF_W;         // signed square
	localparam int ROOT_W    = 35;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int STR_W     = ROOT_W + 1;         // signed stretch
	localparam int SMAG_W    = ROOT_W;
	localparam int PROD_W    = 2 * W;              // |d| * stiffness, below 2^64
	localparam int PP_W      = W + SMAG_W;
	localparam int NUM_W     = PROD_W + SMAG_W;
	localparam int DEN_W     = ROOT_W + FRAC_BITS;
	localparam int Q_W       = W;
	localparam int REM_W     = DEN_W + Q_W;

	localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(32'h7FFF_FFFF);
	localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(32'h8000_0000);

	typedef struct packed {
		logic [2:0][DIFF_W-1:0] mag_d;
		logic [2:0]             neg_d;
		logic [W-1:0]           rest;
		logic [W-1:0]           stiff;
		logic                   zero;
	} sqrt_side_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic zero;
	} div_side_t;

endpackage

// ===== hw/rtl/sfh_if.sv =====
interface sfh_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_a_x;
	logic [31:0] pos_a_y;
	logic [31:0] pos_a_z;
	logic [31:0] pos_b_x;
	logic [31:0] pos_b_y;
	logic [31:0] pos_b_z;
	logic [31:0] rest_length;

	modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
		rest_length, input ready);
	modport sink (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
		rest_length, output ready);
endinterface

interface sfh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] force_x;
	logic [31:0] force_y;
	logic [31:0] force_z;
	logic        zero_distance;
	logic        saturated;

	modport source (output valid, force_x, force_y, force_z, zero_distance, saturated,
		input ready);
	modport sink (input valid, force_x, force_y, force_z, zero_distance, saturated,
		output ready);
endinterface

// ===== hw/rtl/sfh_sqrt.sv =====
// One root bit per stage; x holds radicand minus root squared.
module sfh_sqrt import sfh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  rad,
	input  sqrt_side_t        in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output sqrt_side_t        out_side
);

	logic [ROOT_W:1]   v_s;
	logic [RAD_W-1:0]  x_s    [1:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	sqrt_side_t        side_s [1:ROOT_W];

	genvar k;
	generate
		for (k = 0; k < ROOT_W; k++) begin : g_stage
			localparam int B = ROOT_W - 1 - k;
			logic              vi;
			logic [RAD_W-1:0]  xi;
			logic [ROOT_W-1:0] ri;
			sqrt_side_t        si;
			logic [RAD_W-1:0]  t;
			logic              take;

			if (k == 0) begin : g_first
				assign vi = in_valid;
				assign xi = rad;
				assign ri = '0;
				assign si = in_side;
			end else begin : g_next
				assign vi = v_s[k];
				assign xi = x_s[k];
				assign ri = root_s[k];
				assign si = side_s[k];
			end

			// (r + 2^B)^2 - r^2
			assign t    = (RAD_W'(ri) << (B + 1)) | (RAD_W'(1) << (2 * B));
			assign take = xi >= t;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k+1] <= 1'b0;
				else if (en) v_s[k+1] <= vi;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[k+1] <= take ? (ri | (ROOT_W'(1) << B)) : ri;
					side_s[k+1] <= si;
				end
			end

			if (k < ROOT_W - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) x_s[k+1] <= take ? (xi - t) : xi;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];

endmodule

// ===== hw/rtl/sfh_div.sv =====
// Restoring divide, one quotient bit per stage. Caller guarantees num < den << Q_W.
module sfh_div import sfh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [REM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  div_side_t        in_side,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output div_side_t        out_side
);

	logic [Q_W:1]       v_s;
	logic [REM_W-1:0]   rem_s  [1:Q_W-1];
	logic [DEN_W-1:0]   den_s  [1:Q_W-1];
	logic [Q_W-1:0]     q_s    [1:Q_W];
	div_side_t          side_s [1:Q_W];

	genvar k;
	generate
		for (k = 0; k < Q_W; k++) begin : g_stage
			localparam int B = Q_W - 1 - k;
			logic             vi;
			logic [REM_W-1:0] ri;
			logic [DEN_W-1:0] di;
			logic [Q_W-1:0]   qi;
			div_side_t        si;
			logic [REM_W-1:0] t;
			logic             take;

			if (k == 0) begin : g_first
				assign vi = in_valid;
				assign ri = num;
				assign di = den;
				assign qi = '0;
				assign si = in_side;
			end else begin : g_next
				assign vi = v_s[k];
				assign ri = rem_s[k];
				assign di = den_s[k];
				assign qi = q_s[k];
				assign si = side_s[k];
			end

			assign t    = REM_W'(di) << B;
			assign take = ri >= t;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k+1] <= 1'b0;
				else if (en) v_s[k+1] <= vi;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					q_s[k+1]    <= take ? (qi | (Q_W'(1) << B)) : qi;
					side_s[k+1] <= si;
				end
			end

			if (k < Q_W - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k+1] <= take ? (ri - t) : ri;
						den_s[k+1] <= di;
					end
				end
			end
		end
	endgenerate

	assign out_valid = v_s[Q_W];
	assign quo       = q_s[Q_W];
	assign out_side  = side_s[Q_W];

endmodule

// ===== hw/rtl/spring_force_hooke.sv =====
// Hooke spring force, 3D, signed fixed point with FRAC_BITS fraction bits.
// spring_in: one spring per transfer (end A, end B, rest length).
// force_out: one result per spring, in order: force on end B (end A gets its
//   negation), zero_distance when the ends coincide (force zero), saturated
//   when any component was clipped to the signed 32-bit range.
// cfg_we / cfg_wdata: writes the stiffness register (reset 1.0). Write only
//   while no spring is in flight.
// Pipeline: 75 register stages: 3 front stages, 35 square-root stages
//   (one root bit each), 4 stages for stretch, products and overflow check,
//   32 divider stages (one quotient bit each), 1 output register.
// Throughput: one spring per cycle. All stages share one advance enable;
//   when force_out stalls with a result waiting, the whole pipe holds and
//   spring_in.ready drops, so nothing is lost or repeated. Bubbles do not
//   block: an empty output register lets the pipe advance.
// Reset: clears all valid bits and loads stiffness with 1.0; the pipe is
//   ready in the first cycle after reset.
module spring_force_hooke import sfh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sfh_in_if.sink       spring_in,
	sfh_out_if.source    force_out,
	input  logic         cfg_we,
	input  logic [W-1:0] cfg_wdata
);

	logic         en;
	logic [W-1:0] stiffness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stiffness_q <= W'(1) << FRAC_BITS;
		else if (cfg_we) stiffness_q <= cfg_wdata;
	end

	// stage 1: differences
	logic                           v_s1;
	logic signed [2:0][DIFF_W-1:0]  d_s1;
	logic [W-1:0]                   rest_s1, stiff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= spring_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0]  <= {spring_in.pos_b_x[W-1], spring_in.pos_b_x}
				- {spring_in.pos_a_x[W-1], spring_in.pos_a_x};
			d_s1[1]  <= {spring_in.pos_b_y[W-1], spring_in.pos_b_y}
				- {spring_in.pos_a_y[W-1], spring_in.pos_a_y};
			d_s1[2]  <= {spring_in.pos_b_z[W-1], spring_in.pos_b_z}
				- {spring_in.pos_a_z[W-1], spring_in.pos_a_z};
			rest_s1  <= spring_in.rest_length;
			stiff_s1 <= stiffness_q;
		end
	end

	// stage 2: squares and magnitudes
	logic                         v_s2;
	logic [2:0][SQ_W-1:0]         sq_s2;
	logic [2:0][DIFF_W-1:0]       mag_s2;
	logic [2:0]                   neg_s2;
	logic [W-1:0]                 rest_s2, stiff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]  <= SQ_W'($signed(d_s1[i]) * $signed(d_s1[i]));
				mag_s2[i] <= d_s1[i][DIFF_W-1] ? (DIFF_W'(0) - d_s1[i]) : d_s1[i];
				neg_s2[i] <= d_s1[i][DIFF_W-1];
			end
			rest_s2  <= rest_s1;
			stiff_s2 <= stiff_s1;
		end
	end

	// stage 3: sum of squares
	logic             v_s3;
	logic [RAD_W-1:0] sum_s3;
	sqrt_side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3        <= RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2]);
			side_s3.mag_d <= mag_s2;
			side_s3.neg_d <= neg_s2;
			side_s3.rest  <= rest_s2;
			side_s3.stiff <= stiff_s2;
			side_s3.zero  <= (mag_s2[0] == '0) && (mag_s2[1] == '0) && (mag_s2[2] == '0);
		end
	end

	logic              sq_v;
	logic [ROOT_W-1:0] len;
	sqrt_side_t        sq_side;

	sfh_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.rad       (sum_s3),
		.in_side   (side_s3),
		.out_valid (sq_v),
		.root      (len),
		.out_side  (sq_side)
	);

	// stage 4: stretch, |d| * stiffness, divisor
	logic                   v_s4;
	logic signed [STR_W-1:0] str;
	logic [SMAG_W-1:0]      smag_s4;
	logic                   sneg_s4;
	logic [2:0][PROD_W-1:0] p_s4;
	logic [2:0]             negd_s4;
	logic [DEN_W-1:0]       den_s4;
	logic                   zero_s4;

	assign str = $signed(STR_W'(sq_side.rest)) - $signed(STR_W'(len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sq_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sneg_s4 <= str[STR_W-1];
			smag_s4 <= str[STR_W-1] ? SMAG_W'(-str) : SMAG_W'(str);
			for (int i = 0; i < 3; i++)
				p_s4[i] <= PROD_W'(sq_side.mag_d[i] * sq_side.stiff);
			negd_s4 <= sq_side.neg_d;
			// coinciding ends: dummy divisor, result overridden at the output
			den_s4  <= sq_side.zero ? DEN_W'(1) : (DEN_W'(len) << FRAC_BITS);
			zero_s4 <= sq_side.zero;
		end
	end

	// stage 5: partial products against |stretch|
	logic                 v_s5;
	logic [2:0][PP_W-1:0] plo_s5, phi_s5;
	logic [2:0]           neg_s5;
	logic [DEN_W-1:0]     den_s5;
	logic                 zero_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				plo_s5[i] <= PP_W'(p_s4[i][W-1:0] * smag_s4);
				phi_s5[i] <= PP_W'(p_s4[i][PROD_W-1:W] * smag_s4);
				neg_s5[i] <= negd_s4[i] ^ sneg_s4;
			end
			den_s5  <= den_s4;
			zero_s5 <= zero_s4;
		end
	end

	// stage 6: full numerator
	logic                  v_s6;
	logic [2:0][NUM_W-1:0] num_s6;
	logic [2:0]            neg_s6;
	logic [DEN_W-1:0]      den_s6;
	logic                  zero_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				num_s6[i] <= NUM_W'(plo_s5[i]) + (NUM_W'(phi_s5[i]) << W);
			neg_s6  <= neg_s5;
			den_s6  <= den_s5;
			zero_s6 <= zero_s5;
		end
	end

	// stage 7: quotient overflow check (quotient >= 2^32 always clips)
	logic                  v_s7;
	logic [2:0][REM_W-1:0] num_s7;
	div_side_t [2:0]       dside_s7;
	logic [DEN_W-1:0]      den_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s7[i]        <= num_s6[i][REM_W-1:0];
				dside_s7[i].ovf  <= num_s6[i] >= (NUM_W'(den_s6) << Q_W);
				dside_s7[i].neg  <= neg_s6[i];
				dside_s7[i].zero <= zero_s6;
			end
			den_s7 <= den_s6;
		end
	end

	logic [2:0]            dv;
	logic [2:0][Q_W-1:0]   quo;
	div_side_t [2:0]       dside;

	genvar c;
	generate
		for (c = 0; c < 3; c++) begin : g_div
			sfh_div u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (v_s7),
				.num       (num_s7[c]),
				.den       (den_s7),
				.in_side   (dside_s7[c]),
				.out_valid (dv[c]),
				.quo       (quo[c]),
				.out_side  (dside[c])
			);
		end
	endgenerate

	// clip and sign
	logic [2:0][W-1:0] fval;
	logic [2:0]        fsat;

	always_comb begin
		logic [Q_W-1:0] limit;
		logic [Q_W-1:0] m;
		for (int i = 0; i < 3; i++) begin
			limit   = dside[i].neg ? NEG_LIMIT : POS_LIMIT;
			fsat[i] = dside[i].ovf || (quo[i] > limit);
			m       = fsat[i] ? limit : quo[i];
			fval[i] = dside[i].neg ? (W'(0) - m) : m;
		end
	end

	logic              out_v_q;
	logic [2:0][W-1:0] force_q;
	logic              zero_q, sat_q;

	assign en = !out_v_q || force_out.ready;
	assign spring_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q  <= dside[0].zero;
			sat_q   <= !dside[0].zero && (fsat != 3'b000);
			force_q <= dside[0].zero ? '0 : fval;
		end
	end

	assign force_out.valid         = out_v_q;
	assign force_out.force_x       = force_q[0];
	assign force_out.force_y       = force_q[1];
	assign force_out.force_z       = force_q[2];
	assign force_out.zero_distance = zero_q;
	assign force_out.saturated     = sat_q;

endmodule
